// File: src/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared constants and codes for the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

  // default sizing of the scheduler
  localparam int unsigned LEVELS_DEF = 8;
  localparam int unsigned PROCS_DEF  = 16;

  // field widths
  localparam int unsigned CMD_W     = 1;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned EVENT_W   = 3;
  localparam int unsigned PID_W     = 5;
  localparam int unsigned LABEL_W   = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NLEV_W     = 4;
  localparam int unsigned NPROC_W    = 5;
  localparam int unsigned PERIOD_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_LEVELS   = 2'd0,
    CFG_NUM_PROCS    = 2'd1,
    CFG_BOOST_PERIOD = 2'd2
  } cfg_idx_e;

  localparam logic [NLEV_W-1:0]   NUM_LEVELS_RST   = 4'd8;
  localparam logic [NPROC_W-1:0]  NUM_PROCS_RST    = 5'd16;
  localparam logic [PERIOD_W-1:0] BOOST_PERIOD_RST = 16'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 1'b0,
    CMD_SLICE = 1'b1
  } cmd_e;

  // outcome code 3 is taken as finished
  typedef enum logic [OUTCOME_W-1:0] {
    OC_YIELD  = 2'd0,
    OC_FULL   = 2'd1,
    OC_FINISH = 2'd2
  } outcome_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_FULL  = 3'd0,
    EV_YIELD = 3'd1,
    EV_EXIT  = 3'd2,
    EV_BOOST = 3'd3,
    EV_IDLE  = 3'd4
  } event_e;

endpackage

`default_nettype wire

// File: src/mfs_in_if.sv
// ----------------------------------------------------------------------------
// mfs_in_if
// Command channel of the scheduler: start or slice outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfs_in_if;
  logic                             valid;
  logic                             ready;
  logic [mfs_pkg::CMD_W-1:0]        cmd;
  logic [mfs_pkg::OUTCOME_W-1:0]    outcome;

  modport source (output valid, output cmd, output outcome, input ready);
  modport sink   (input valid, input cmd, input outcome, output ready);
endinterface

`default_nettype wire

// File: src/mfs_out_if.sv
// ----------------------------------------------------------------------------
// mfs_out_if
// Result channel of the scheduler: one event per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfs_out_if;
  logic                             valid;
  logic                             ready;
  logic [mfs_pkg::EVENT_W-1:0]      event_res;
  logic [mfs_pkg::PID_W-1:0]        proc_id;
  logic [mfs_pkg::LABEL_W-1:0]      level_label;
  logic                             last;

  modport source (output valid, output event_res, output proc_id, output level_label,
                  output last, input ready);
  modport sink   (input valid, input event_res, input proc_id, input level_label,
                  input last, output ready);
endinterface

`default_nettype wire

// File: src/mfs_queue_ram.sv
// ----------------------------------------------------------------------------
// mfs_queue_ram
// Queue slot store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_queue_ram #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned DATA_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/multilevel_feedback_scheduler.sv
// Start: level 0 is loaded in ST_FILL, one queue slot written a cycle.
// Slice: result through ST_PICK, ST_PUSH, ST_EMIT into the output register;
// idle skips ST_PUSH; each boost move adds a read, write and emit step.
// A new item is taken once the last result of the previous one is registered.
// Reset: registers to 8 levels, 16 procs, period 0; all levels empty.
// The queue slot store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Multi-level feedback queue scheduler: per-level FIFOs in one slot store,
// walked by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_feedback_scheduler #(
  parameter int unsigned LEVELS = mfs_pkg::LEVELS_DEF,
  parameter int unsigned PROCS  = mfs_pkg::PROCS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mfs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  mfs_in_if.sink                           in_if,
  mfs_out_if.source                        out_if
);

  localparam int unsigned SLOT_W = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned CNT_W  = $clog2(PROCS + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned NL_W   = $clog2(LEVELS + 1);
  localparam int unsigned DEPTH  = LEVELS * PROCS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FILL = 7'b0000010,
    ST_PICK = 7'b0000100,
    ST_PUSH = 7'b0001000,
    ST_EMIT = 7'b0010000,
    ST_BRD  = 7'b0100000,
    ST_BWR  = 7'b1000000
  } state_e;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lv,
                                                input logic [SLOT_W-1:0] slot);
    addr_of = ADDR_W'(int'(lv) * PROCS + int'(slot));
  endfunction

  // configuration
  logic [mfs_pkg::NLEV_W-1:0]   num_levels_q;
  logic [mfs_pkg::NPROC_W-1:0]  num_procs_q;
  logic [mfs_pkg::PERIOD_W-1:0] boost_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q   <= mfs_pkg::NUM_LEVELS_RST;
      num_procs_q    <= mfs_pkg::NUM_PROCS_RST;
      boost_period_q <= mfs_pkg::BOOST_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mfs_pkg::CFG_NUM_LEVELS:   num_levels_q   <= cfg_wdata_i[mfs_pkg::NLEV_W-1:0];
        mfs_pkg::CFG_NUM_PROCS:    num_procs_q    <= cfg_wdata_i[mfs_pkg::NPROC_W-1:0];
        mfs_pkg::CFG_BOOST_PERIOD: boost_period_q <= cfg_wdata_i[mfs_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  state_e                        state_q, state_d;
  logic [SLOT_W-1:0]             head_q [LEVELS];
  logic [CNT_W-1:0]              cnt_q  [LEVELS];
  logic [mfs_pkg::PERIOD_W-1:0]  slice_q;
  logic [mfs_pkg::OUTCOME_W-1:0] outcome_q;
  logic [LVL_W-1:0]              cur_lv_q;
  logic [SLOT_W-1:0]             fill_q;
  logic                          boost_pend_q;
  logic [mfs_pkg::EVENT_W-1:0]   res_ev_q;
  logic [mfs_pkg::PID_W-1:0]     res_id_q;
  logic [mfs_pkg::LABEL_W-1:0]   res_lab_q;
  logic                          ov_q;
  logic [mfs_pkg::EVENT_W-1:0]   o_ev_q;
  logic [mfs_pkg::PID_W-1:0]     o_id_q;
  logic [mfs_pkg::LABEL_W-1:0]   o_lab_q;
  logic                          o_last_q;

  // derived
  logic [NL_W-1:0]   nl;
  logic [CNT_W-1:0]  np;
  logic              pick_found;
  logic [LVL_W-1:0]  pick_lv;
  logic              low_found;
  logic [LVL_W-1:0]  low_lv;
  logic              cnt0_lt;
  logic              pick_ok;
  logic              is_full;
  logic              do_push;
  logic [LVL_W-1:0]  dest;
  logic [LVL_W-1:0]  tail_lv;
  logic [SUM_W-1:0]  tail_sum;
  logic [SLOT_W-1:0] tail_slot;
  logic              more;
  logic              slot_free;
  logic              in_fire;
  logic              emit_fire;
  logic [mfs_pkg::PERIOD_W-1:0] slice_inc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  always_comb begin
    if (num_levels_q == '0) begin
      nl = NL_W'(1);
    end else if (int'(num_levels_q) > int'(LEVELS)) begin
      nl = NL_W'(LEVELS);
    end else begin
      nl = NL_W'(num_levels_q);
    end
    if (int'(num_procs_q) > int'(PROCS)) begin
      np = CNT_W'(PROCS);
    end else begin
      np = CNT_W'(num_procs_q);
    end
  end

  // highest non-empty level in use, and highest non-empty level below the top
  always_comb begin
    pick_found = 1'b0;
    pick_lv    = '0;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (cnt_q[lv] != '0 && lv < int'(nl)) begin
        pick_found = 1'b1;
        pick_lv    = LVL_W'(lv);
      end
    end
    low_found = 1'b0;
    low_lv    = '0;
    for (int p = LEVELS - 1; p >= 1; p--) begin
      if (cnt_q[p] != '0) begin
        low_found = 1'b1;
        low_lv    = LVL_W'(p);
      end
    end
  end

  assign cnt0_lt = (cnt_q[0] < CNT_W'(PROCS));
  assign pick_ok = pick_found && (boost_period_q != '0);
  assign is_full = (outcome_q == mfs_pkg::OC_FULL);
  assign do_push = is_full || (outcome_q == mfs_pkg::OC_YIELD);

  always_comb begin
    if (is_full && (int'(cur_lv_q) + 1 < int'(nl))) begin
      dest = LVL_W'(int'(cur_lv_q) + 1);
    end else begin
      dest = cur_lv_q;
    end
  end

  // back of the destination queue, wrapped into its slot ring
  assign tail_lv  = (state_q == ST_PUSH) ? dest : '0;
  assign tail_sum = SUM_W'(head_q[tail_lv]) + SUM_W'(cnt_q[tail_lv]);
  assign tail_slot = (tail_sum >= SUM_W'(PROCS)) ? SLOT_W'(tail_sum - SUM_W'(PROCS))
                                                  : SLOT_W'(tail_sum);

  assign more      = boost_pend_q && low_found && cnt0_lt;
  assign slot_free = !ov_q || out_if.ready;
  assign in_fire   = in_if.valid && (state_q == ST_IDLE);
  assign emit_fire = (state_q == ST_EMIT) && slot_free;
  assign slice_inc = slice_q + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of('0, fill_q);
    ram_wdata = fill_q;
    ram_re    = 1'b0;
    ram_raddr = addr_of(pick_lv, head_q[pick_lv]);
    case (state_q)
      ST_FILL: ram_we = 1'b1;
      ST_PICK: ram_re = pick_ok;
      ST_PUSH: begin
        ram_we    = do_push && (cnt_q[dest] < CNT_W'(PROCS));
        ram_waddr = addr_of(dest, tail_slot);
        ram_wdata = ram_rdata;
      end
      ST_BRD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(low_lv, head_q[low_lv]);
      end
      ST_BWR: begin
        ram_we    = cnt0_lt;
        ram_waddr = addr_of('0, tail_slot);
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  mfs_queue_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SLOT_W)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_if.cmd == mfs_pkg::CMD_START) begin
            state_d = (np == '0) ? ST_IDLE : ST_FILL;
          end else begin
            state_d = ST_PICK;
          end
        end
      end
      ST_FILL: begin
        if (int'(fill_q) + 1 >= int'(np)) begin
          state_d = ST_IDLE;
        end
      end
      ST_PICK: state_d = pick_ok ? ST_PUSH : ST_EMIT;
      ST_PUSH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_d = more ? ST_BRD : ST_IDLE;
        end
      end
      ST_BRD:  state_d = ST_BWR;
      ST_BWR:  state_d = ST_EMIT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slice_q      <= '0;
      fill_q       <= '0;
      boost_pend_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire && in_if.cmd == mfs_pkg::CMD_START) begin
            for (int i = 0; i < LEVELS; i++) begin
              head_q[i] <= '0;
              cnt_q[i]  <= '0;
            end
            cnt_q[0] <= np;
            slice_q  <= '0;
            fill_q   <= '0;
          end
        end
        ST_FILL: fill_q <= fill_q + 1'b1;
        ST_PICK: begin
          if (pick_ok) begin
            head_q[pick_lv] <= (head_q[pick_lv] == SLOT_W'(PROCS - 1)) ? '0
                                                                       : head_q[pick_lv] + 1'b1;
            cnt_q[pick_lv]  <= cnt_q[pick_lv] - 1'b1;
          end else begin
            boost_pend_q <= 1'b0;
          end
        end
        ST_PUSH: begin
          if (do_push && cnt_q[dest] < CNT_W'(PROCS)) begin
            cnt_q[dest] <= cnt_q[dest] + 1'b1;
          end
          boost_pend_q <= (slice_inc >= boost_period_q);
          slice_q      <= (slice_inc >= boost_period_q) ? '0 : slice_inc;
        end
        ST_BRD: begin
          head_q[low_lv] <= (head_q[low_lv] == SLOT_W'(PROCS - 1)) ? '0
                                                                   : head_q[low_lv] + 1'b1;
          cnt_q[low_lv]  <= cnt_q[low_lv] - 1'b1;
        end
        ST_BWR: begin
          if (cnt0_lt) begin
            cnt_q[0] <= cnt_q[0] + 1'b1;
          end
          boost_pend_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result fields, held until the emit step
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: outcome_q <= in_if.outcome;
      ST_PICK: begin
        cur_lv_q  <= pick_lv;
        res_ev_q  <= mfs_pkg::EV_IDLE;
        res_id_q  <= '0;
        res_lab_q <= '0;
      end
      ST_PUSH: begin
        res_id_q <= mfs_pkg::PID_W'(int'(ram_rdata) + 1);
        if (is_full) begin
          res_ev_q  <= mfs_pkg::EV_FULL;
          res_lab_q <= mfs_pkg::LABEL_W'(int'(nl) - int'(dest));
        end else if (do_push) begin
          res_ev_q  <= mfs_pkg::EV_YIELD;
          res_lab_q <= mfs_pkg::LABEL_W'(int'(nl) - int'(cur_lv_q));
        end else begin
          res_ev_q  <= mfs_pkg::EV_EXIT;
          res_lab_q <= '0;
        end
      end
      ST_BWR: begin
        res_ev_q  <= mfs_pkg::EV_BOOST;
        res_id_q  <= mfs_pkg::PID_W'(int'(ram_rdata) + 1);
        res_lab_q <= mfs_pkg::LABEL_W'(nl);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit_fire) begin
      ov_q <= 1'b1;
    end else if (out_if.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      o_ev_q   <= res_ev_q;
      o_id_q   <= res_id_q;
      o_lab_q  <= res_lab_q;
      o_last_q <= !more;
    end
  end

  assign in_if.ready        = (state_q == ST_IDLE);
  assign out_if.valid       = ov_q;
  assign out_if.event_res   = o_ev_q;
  assign out_if.proc_id     = o_id_q;
  assign out_if.level_label = o_lab_q;
  assign out_if.last        = o_last_q;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multilevel feedback scheduler. A driver sends
// start and slice commands in random bursts, a shadow scheduler predicts every
// event, and a monitor compares each result transfer while the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------

module testbench;
  import mfs_pkg::*;

  localparam int unsigned LV          = LEVELS_DEF;
  localparam int unsigned PR          = PROCS_DEF;
  localparam int unsigned SLOT_W      = $clog2(PR);
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned ITEM_TARGET = 410;
  localparam longint unsigned CYCLE_LIMIT = 600000;

  // outcome code with no name of its own in the package; taken as finished
  localparam logic [OUTCOME_W-1:0] OC_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [OUTCOME_W-1:0] outcome;
  } sched_cmd_t;

  typedef struct packed {
    event_e               ev;
    logic [PID_W-1:0]     pid;
    logic [LABEL_W-1:0]   label;
    logic                 last;
  } sched_event_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  mfs_in_if  cmd_bus ();
  mfs_out_if evt_bus ();

  multilevel_feedback_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (cmd_bus),
    .out_if      (evt_bus)
  );

  always #5 clk_i = ~clk_i;

  // shadow registers and queues of the scheduler
  logic [NLEV_W-1:0]   sh_levels = NUM_LEVELS_RST;
  logic [NPROC_W-1:0]  sh_procs  = NUM_PROCS_RST;
  logic [PERIOD_W-1:0] sh_period = BOOST_PERIOD_RST;
  logic [SLOT_W-1:0]   slot_mem [LV*PR];
  int unsigned         lvl_head [LV];
  int unsigned         lvl_count [LV];
  logic [PERIOD_W-1:0] slices_since = '0;

  sched_cmd_t   cmd_backlog [$];
  sched_event_t due_events [$];

  int unsigned n_queued, n_taken, n_results, n_boosts, n_idles, n_phases, errors;
  int unsigned burst_left, gap_left;
  int unsigned stall_left, stall_pct, stall_max, mode_left;
  longint unsigned cycles;

  function automatic void lvl_push(int unsigned lv, logic [PID_W-1:0] id);
    int unsigned slot;
    if (lv >= LV || lvl_count[lv] >= PR) return;
    slot = (lvl_head[lv] + lvl_count[lv]) % PR;
    slot_mem[lv*PR + slot] = SLOT_W'(id - 1);
    lvl_count[lv]++;
  endfunction

  function automatic logic [PID_W-1:0] lvl_pop(int unsigned lv);
    logic [PID_W-1:0] id;
    id = PID_W'(slot_mem[lv*PR + lvl_head[lv]]) + 1'b1;
    lvl_head[lv] = (lvl_head[lv] + 1) % PR;
    lvl_count[lv]--;
    return id;
  endfunction

  function automatic void sched_predict(logic [CMD_W-1:0] c, logic [OUTCOME_W-1:0] oc);
    int unsigned nl, np, lv, dest, p;
    logic [PID_W-1:0] id, m;
    sched_event_t burst [$];
    nl = sh_levels;
    if (nl < 1) nl = 1;
    if (nl > LV) nl = LV;

    if (c == CMD_START) begin
      np = (sh_procs > PR) ? PR : sh_procs;
      foreach (lvl_head[i]) begin
        lvl_head[i]  = 0;
        lvl_count[i] = 0;
      end
      for (p = 1; p <= np; p++) lvl_push(0, PID_W'(p));
      slices_since = '0;
      return;
    end

    for (lv = 0; lv < nl; lv++)
      if (lvl_count[lv] != 0) break;

    if (sh_period == 0 || lv >= nl) begin
      due_events.insert(due_events.size(), sched_event_t'{EV_IDLE, '0, '0, 1'b1});
      return;
    end

    id = lvl_pop(lv);
    if (oc == OC_FULL) begin
      dest = (lv + 1 < nl) ? lv + 1 : lv;
      lvl_push(dest, id);
      burst.insert(burst.size(), sched_event_t'{EV_FULL, id, LABEL_W'(nl - dest), 1'b0});
    end else if (oc == OC_YIELD) begin
      lvl_push(lv, id);
      burst.insert(burst.size(), sched_event_t'{EV_YIELD, id, LABEL_W'(nl - lv), 1'b0});
    end else begin
      burst.insert(burst.size(), sched_event_t'{EV_EXIT, id, '0, 1'b0});
    end

    slices_since = slices_since + 1'b1;
    if (slices_since >= sh_period) begin
      // boost walks every level below the top, in use or not
      for (lv = 1; lv < LV; lv++)
        while (lvl_count[lv] != 0 && lvl_count[0] < PR && burst.size() < 1 + PR) begin
          m = lvl_pop(lv);
          lvl_push(0, m);
          burst.insert(burst.size(), sched_event_t'{EV_BOOST, m, LABEL_W'(nl), 1'b0});
        end
      slices_since = '0;
    end

    burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) due_events.insert(due_events.size(), burst[i]);
  endfunction

  // command driver: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    sched_cmd_t nxt;
    if (rst_ni) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        sched_predict(cmd_bus.cmd, cmd_bus.outcome);
        n_taken++;
      end
      if (!(cmd_bus.valid && !cmd_bus.ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          cmd_bus.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          cmd_bus.valid   <= 1'b1;
          cmd_bus.cmd     <= nxt.cmd;
          cmd_bus.outcome <= nxt.outcome;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(1) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // event monitor and receiver stall pattern
  always @(posedge clk_i) begin
    sched_event_t want;
    if (rst_ni) begin
      if (evt_bus.valid && evt_bus.ready) begin
        n_results++;
        if (due_events.size() == 0) begin
          $error("unexpected result: event_res %0d proc_id %0d level_label %0d",
                 evt_bus.event_res, evt_bus.proc_id, evt_bus.level_label);
          errors++;
        end else begin
          want = due_events.pop_front();
          if (evt_bus.event_res !== want.ev) begin
            $error("event_res: expected %0d, actual %0d", want.ev, evt_bus.event_res);
            errors++;
          end
          if (evt_bus.proc_id !== want.pid) begin
            $error("proc_id: expected %0d, actual %0d", want.pid, evt_bus.proc_id);
            errors++;
          end
          if (evt_bus.level_label !== want.label) begin
            $error("level_label: expected %0d, actual %0d", want.label, evt_bus.level_label);
            errors++;
          end
          if (evt_bus.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, evt_bus.last);
            errors++;
          end
          if (want.ev == EV_BOOST) n_boosts++;
          if (want.ev == EV_IDLE) n_idles++;
        end
      end

      if (stall_left != 0) begin
        stall_left--;
        evt_bus.ready <= 1'b0;
      end else begin
        evt_bus.ready <= 1'b1;
        if ($urandom_range(99) < stall_pct) stall_left = $urandom_range(stall_max, 1);
      end

      // switch between free-flowing, light and heavy back-pressure
      if (mode_left == 0) begin
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_max = $urandom_range(8, 1);
        mode_left = $urandom_range(300, 40);
      end else begin
        mode_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic queue_item(logic [CMD_W-1:0] c, logic [OUTCOME_W-1:0] oc);
    cmd_backlog.insert(cmd_backlog.size(), sched_cmd_t'{c, oc});
    n_queued++;
  endtask

  // hold off until every command is taken and every event has come back
  task automatic drain();
    while (n_taken != n_queued || due_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_NUM_LEVELS:   sh_levels = data[NLEV_W-1:0];
      CFG_NUM_PROCS:    sh_procs  = data[NPROC_W-1:0];
      CFG_BOOST_PERIOD: sh_period = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] nl, np, bp);
    write_reg(CFG_NUM_LEVELS, nl);
    write_reg(CFG_NUM_PROCS, np);
    write_reg(CFG_BOOST_PERIOD, bp);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_levels();
    int unsigned r;
    logic [CFG_DATA_W-1:0] v;
    r = $urandom_range(99);
    if (r < 10)      v = 0;
    else if (r < 20) v = $urandom_range(15, 9);
    else if (r < 30) v = LV;
    else             v = $urandom_range(7, 1);
    // junk above the field must be ignored
    if ($urandom_range(3) == 0) v = v | (CFG_DATA_W'($urandom) << NLEV_W);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(8, 1);
    if (r < 80) return $urandom_range(40, 9);
    if (r < 87) return 0;
    if (r < 94) return 16'hFFFF;
    return $urandom_range(65535);
  endfunction

  function automatic logic [OUTCOME_W-1:0] rand_outcome();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return OC_FULL;
    if (r < 75) return OC_YIELD;
    if (r < 95) return OC_FINISH;
    return OC_UNKNOWN;
  endfunction

  initial begin
    int unsigned len, split, k, r;
    logic [CFG_DATA_W-1:0] np;
    cmd_bus.valid   = 1'b0;
    cmd_bus.cmd     = CMD_START;
    cmd_bus.outcome = OC_YIELD;
    evt_bus.ready   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: scheduling disabled, queues empty then full
    queue_item(CMD_SLICE, OC_FULL);
    queue_item(CMD_START, OC_UNKNOWN);
    queue_item(CMD_SLICE, OC_YIELD);
    queue_item(CMD_SLICE, OC_FINISH);
    drain();

    // demotion, yield, exit, boost on the fifth slice, unknown outcome
    set_regs(3, 4, 5);
    queue_item(CMD_START, OC_YIELD);
    queue_item(CMD_SLICE, OC_FULL);
    queue_item(CMD_SLICE, OC_FULL);
    queue_item(CMD_SLICE, OC_YIELD);
    queue_item(CMD_SLICE, OC_FULL);
    queue_item(CMD_SLICE, OC_FINISH);
    queue_item(CMD_SLICE, OC_UNKNOWN);
    queue_item(CMD_SLICE, OC_FULL);
    drain();

    // zero levels act as one, zero processes load nothing
    set_regs(0, 0, 1);
    queue_item(CMD_START, OC_FULL);
    queue_item(CMD_SLICE, OC_FULL);
    drain();

    // counts above range are clamped, boost after every slice
    set_regs(15, 31, 1);
    queue_item(CMD_START, OC_FINISH);
    queue_item(CMD_SLICE, OC_FULL);
    queue_item(CMD_SLICE, OC_YIELD);
    drain();

    // processes parked below the levels in use, then a lowered period
    set_regs(LV, 6, 16'hFFFF);
    queue_item(CMD_START, OC_YIELD);
    repeat (6) queue_item(CMD_SLICE, OC_FULL);
    drain();
    write_reg(CFG_NUM_LEVELS, 1);
    queue_item(CMD_SLICE, OC_YIELD);
    drain();
    write_reg(CFG_NUM_LEVELS, 2);
    write_reg(CFG_BOOST_PERIOD, 2);
    queue_item(CMD_SLICE, OC_FULL);
    drain();

    while (n_queued < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 8)       np = 0;
      else if (r < 16) np = $urandom_range(31, 17);
      else if (r < 30) np = PR;
      else             np = $urandom_range(15, 1);
      if ($urandom_range(3) == 0) np = np | (CFG_DATA_W'($urandom) << NPROC_W);
      set_regs(pick_levels(), np, pick_period());
      n_phases++;

      queue_item(CMD_START, OUTCOME_W'($urandom));
      len   = $urandom_range(40, 8);
      split = ($urandom_range(3) == 0) ? $urandom_range(len - 1, 1) : len;
      for (k = 0; k < len; k++) begin
        if (k == split) begin
          // retune without a restart
          drain();
          write_reg(CFG_NUM_LEVELS, pick_levels());
          write_reg(CFG_BOOST_PERIOD, pick_period());
        end
        if ($urandom_range(49) == 0) queue_item(CMD_START, OUTCOME_W'($urandom));
        else                          queue_item(CMD_SLICE, rand_outcome());
      end
      drain();
    end

    $display("summary: %0d commands, %0d random phases, %0d cycles", n_taken, n_phases, cycles);
    $display("summary: %0d events checked, %0d boost moves, %0d idle", n_results, n_boosts,
             n_idles);
    if (errors == 0) $display("testbench: PASS");
    else             $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: multilevel_feedback_scheduler.f
src/mfs_pkg.sv
src/mfs_in_if.sv
src/mfs_out_if.sv
src/mfs_queue_ram.sv
src/multilevel_feedback_scheduler.sv
verif/testbench.sv
